FILE: rtl/shell_command_lexer_defines.svh
// Assertion macros used by scl_back of the shell command lexer RTL.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef SHELL_COMMAND_LEXER_DEFINES_SVH
`define SHELL_COMMAND_LEXER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SCL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A consequence that must hold in the cycle after the antecedent.
`define SCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/scl_pkg.sv
// Shared types, codes and the character classifier of the shell command lexer.
// Depends on nothing; used by every module of the block but scl_queue.
package scl_pkg;

    // Default line limit and depth of the queue between front and back end.
    localparam int MAX_LINE_DEFAULT    = 4096;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Characters with a meaning to the lexer.
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_AMP    = 8'h26;
    localparam logic [7:0] CHAR_BAR    = 8'h7C;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    // Character classes. The doubling operators share their codes with the
    // pending operator codes, so a class compares directly with it.
    localparam logic [3:0] CLS_OTHER  = 4'd0;
    localparam logic [3:0] CLS_LT     = 4'd1;
    localparam logic [3:0] CLS_GT     = 4'd2;
    localparam logic [3:0] CLS_AMP    = 4'd3;
    localparam logic [3:0] CLS_BAR    = 4'd4;
    localparam logic [3:0] CLS_SEMI   = 4'd5;
    localparam logic [3:0] CLS_SPACE  = 4'd6;
    localparam logic [3:0] CLS_SQUOTE = 4'd7;
    localparam logic [3:0] CLS_DQUOTE = 4'd8;

    // Pending operator code meaning nothing is held.
    localparam logic [2:0] OP_NONE = 3'd0;

    // Token kinds; operators are formed from the pending code.
    localparam logic [3:0] KIND_EMPTY = 4'd0;
    localparam logic [3:0] KIND_WORD  = 4'd1;
    localparam logic [3:0] KIND_SEMI  = 4'd10;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic       eol;
        logic       ovf;
        logic [3:0] cls;
    } scl_ctl_t;

    // One token as held in the output stage.
    typedef struct packed {
        logic [3:0]  kind;
        logic [11:0] start;
        logic [12:0] length;
        logic        ovf;
        logic        last;
    } scl_tok_t;

    // Maps a raw byte to its lexical class.
    function automatic logic [3:0] classify(input logic [7:0] c);
        logic [3:0] cls;
        begin
            case (c)
                CHAR_LT:     cls = CLS_LT;
                CHAR_GT:     cls = CLS_GT;
                CHAR_AMP:    cls = CLS_AMP;
                CHAR_BAR:    cls = CLS_BAR;
                CHAR_SEMI:   cls = CLS_SEMI;
                CHAR_SQUOTE: cls = CLS_SQUOTE;
                CHAR_DQUOTE: cls = CLS_DQUOTE;
                CHAR_SPACE:  cls = CLS_SPACE;
                default: begin
                    if (c >= CHAR_TAB && c <= CHAR_CR) cls = CLS_SPACE;
                    else cls = CLS_OTHER;
                end
            endcase
            return cls;
        end
    endfunction

endpackage

FILE: rtl/scl_queue.sv
// Small first-in first-out queue of registers between the lexer front and back end.
// Depends on no package; width and depth come from parameters.
module scl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             wr_en, rd_en;

    // Handshake on both sides.
    assign wr_ready = (cnt_reg != CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    // Pointer wrap and fill count.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/scl_front.sv
// Front end of the shell command lexer: takes bytes, classifies them and
// tracks the line position and overflow. Depends on scl_pkg.
module scl_front #(
    parameter int MAX_LINE = scl_pkg::MAX_LINE_DEFAULT,
    parameter int AW       = $clog2(MAX_LINE)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // char_code
    input  logic              s_tlast,   // end_of_line
    output logic              q_valid,
    input  logic              q_ready,
    output scl_pkg::scl_ctl_t q_ctl,
    output logic [AW-1:0]     q_at
);

    localparam int PW = $clog2(MAX_LINE + 1);

    logic [PW-1:0] pos_reg, pos_next;
    logic          ovf_reg, ovf_next;
    logic          take;
    logic          at_limit;

    assign s_tready = q_ready;
    assign q_valid  = s_tvalid;
    assign take     = s_tvalid && q_ready;
    assign at_limit = (pos_reg == PW'(MAX_LINE));

    // Classification and position of the byte being offered.
    always_comb begin
        q_ctl.eol = s_tlast;
        q_ctl.cls = scl_pkg::classify(s_tdata);
        q_ctl.ovf = ovf_reg || (!s_tlast && at_limit);
        q_at      = at_limit ? AW'(MAX_LINE - 1) : pos_reg[AW-1:0];
    end

    // Position saturates at the limit; end of line starts a fresh line.
    always_comb begin
        pos_next = pos_reg;
        ovf_next = ovf_reg;
        if (take) begin
            if (s_tlast) begin
                pos_next = '0;
                ovf_next = 1'b0;
            end else if (at_limit) begin
                ovf_next = 1'b1;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

FILE: rtl/scl_back.sv
// Back end of the shell command lexer: runs the token state machine on
// classified items and drives the result channel. Depends on scl_pkg and
// the assertion macros in shell_command_lexer_defines.svh.
`include "shell_command_lexer_defines.svh"

module scl_back #(
    parameter int MAX_LINE = scl_pkg::MAX_LINE_DEFAULT,
    parameter int AW       = $clog2(MAX_LINE)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  scl_pkg::scl_ctl_t q_ctl,
    input  logic [AW-1:0]     q_at,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // token start, token length, line_overflow
    output logic [3:0]        m_tuser,   // token_kind
    output logic              m_tlast    // last_of_run
);

    localparam int PW = $clog2(MAX_LINE + 1);

    // Scan state.
    logic          open_reg, open_next;
    logic          in_word_reg, in_word_next;
    logic          in_quotes_reg, in_quotes_next;
    logic          qdbl_reg, qdbl_next;
    logic [AW-1:0] start_reg, start_next;
    logic [PW-1:0] count_reg, count_next;
    logic [2:0]    pend_reg, pend_next;

    // Output stage and spare slot for the second result of an item.
    scl_pkg::scl_tok_t out_reg, out_next;
    scl_pkg::scl_tok_t spare_reg, spare_next;
    logic              out_v_reg, out_v_next;
    logic              spare_v_reg, spare_v_next;

    logic              pop, out_free;
    logic              a_v, b_v, c_v, go, cnt_en, clr;
    logic [3:0]        a_kind;
    scl_pkg::scl_tok_t tok_a, tok_b, tok_c, first_tok, second_tok;
    logic [1:0]        n_res;

    assign out_free = !out_v_reg || m_tready;
    assign q_ready  = !spare_v_reg && out_free;
    assign pop      = q_valid && q_ready;

    // Token decisions for the item at the head of the queue.
    always_comb begin
        a_v            = 1'b0;
        b_v            = 1'b0;
        c_v            = 1'b0;
        go             = 1'b1;
        cnt_en         = 1'b0;
        clr            = 1'b0;
        a_kind         = {pend_reg, 1'b0};
        open_next      = open_reg;
        in_word_next   = in_word_reg;
        in_quotes_next = in_quotes_reg;
        qdbl_next      = qdbl_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        if (q_ctl.eol) begin
            if (pend_reg != scl_pkg::OP_NONE) a_v = 1'b1;
            else if (in_word_reg || open_reg) b_v = 1'b1;
            clr       = 1'b1;
            pend_next = scl_pkg::OP_NONE;
        end else begin
            // A held operator is settled by the next byte.
            if (pend_reg != scl_pkg::OP_NONE) begin
                a_v       = 1'b1;
                pend_next = scl_pkg::OP_NONE;
                if (q_ctl.cls == {1'b0, pend_reg}) begin
                    a_kind = {pend_reg, 1'b1};
                    go     = 1'b0;
                end
            end
            if (go) begin
                if (in_quotes_reg) begin
                    if ((q_ctl.cls == scl_pkg::CLS_SQUOTE && !qdbl_reg) ||
                        (q_ctl.cls == scl_pkg::CLS_DQUOTE && qdbl_reg)) begin
                        b_v = 1'b1;
                        clr = 1'b1;
                    end else begin
                        cnt_en = 1'b1;
                    end
                end else if (q_ctl.cls == scl_pkg::CLS_SQUOTE ||
                             q_ctl.cls == scl_pkg::CLS_DQUOTE) begin
                    in_quotes_next = 1'b1;
                    qdbl_next      = (q_ctl.cls == scl_pkg::CLS_DQUOTE);
                    in_word_next   = 1'b1;
                    open_next      = 1'b1;
                end else if (q_ctl.cls == scl_pkg::CLS_SPACE) begin
                    if (in_word_reg) begin
                        b_v = 1'b1;
                        clr = 1'b1;
                    end else begin
                        open_next = 1'b1;
                    end
                end else if (q_ctl.cls == scl_pkg::CLS_OTHER) begin
                    cnt_en = 1'b1;
                end else begin
                    // Operator or separator ends any word in progress.
                    b_v = in_word_reg;
                    clr = 1'b1;
                    if (q_ctl.cls == scl_pkg::CLS_SEMI) c_v = 1'b1;
                    else pend_next = q_ctl.cls[2:0];
                end
            end
        end
        // Count one word character, saturating at the line limit.
        if (cnt_en) begin
            if (count_reg == '0) start_next = q_at;
            if (count_reg < PW'(MAX_LINE)) count_next = count_reg + 1'b1;
            in_word_next = 1'b1;
            open_next    = 1'b1;
        end
        if (clr) begin
            open_next      = 1'b0;
            in_word_next   = 1'b0;
            in_quotes_next = 1'b0;
            qdbl_next      = 1'b0;
            start_next     = '0;
            count_next     = '0;
        end
    end

    // Candidate results and their order.
    always_comb begin
        tok_a.kind   = a_kind;
        tok_a.start  = '0;
        tok_a.length = '0;
        tok_a.ovf    = q_ctl.ovf;
        tok_a.last   = 1'b0;

        tok_b.kind   = (count_reg == '0) ? scl_pkg::KIND_EMPTY : scl_pkg::KIND_WORD;
        tok_b.start  = (count_reg == '0) ? 12'd0 : 12'(start_reg);
        tok_b.length = 13'(count_reg);
        tok_b.ovf    = q_ctl.ovf;
        tok_b.last   = 1'b0;

        tok_c.kind   = scl_pkg::KIND_SEMI;
        tok_c.start  = '0;
        tok_c.length = '0;
        tok_c.ovf    = q_ctl.ovf;
        tok_c.last   = 1'b0;

        n_res = 2'(a_v) + 2'(b_v) + 2'(c_v);

        if (a_v) first_tok = tok_a;
        else if (b_v) first_tok = tok_b;
        else first_tok = tok_c;
        first_tok.last = (n_res == 2'd1);

        if (a_v && b_v) second_tok = tok_b;
        else second_tok = tok_c;
        second_tok.last = 1'b1;
    end

    // Output stage: a new item enters while the previous result is taken.
    always_comb begin
        out_next     = out_reg;
        out_v_next   = out_v_reg;
        spare_next   = spare_reg;
        spare_v_next = spare_v_reg;
        if (pop) begin
            if (n_res != 2'd0) begin
                out_next   = first_tok;
                out_v_next = 1'b1;
            end else begin
                out_v_next = 1'b0;
            end
            if (n_res == 2'd2) begin
                spare_next   = second_tok;
                spare_v_next = 1'b1;
            end
        end else if (spare_v_reg && out_free) begin
            out_next     = spare_reg;
            out_v_next   = 1'b1;
            spare_v_next = 1'b0;
        end else if (m_tready) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg      <= 1'b0;
            in_word_reg   <= 1'b0;
            in_quotes_reg <= 1'b0;
            qdbl_reg      <= 1'b0;
            start_reg     <= '0;
            count_reg     <= '0;
            pend_reg      <= scl_pkg::OP_NONE;
            out_v_reg     <= 1'b0;
            spare_v_reg   <= 1'b0;
        end else begin
            if (pop) begin
                open_reg      <= open_next;
                in_word_reg   <= in_word_next;
                in_quotes_reg <= in_quotes_next;
                qdbl_reg      <= qdbl_next;
                start_reg     <= start_next;
                count_reg     <= count_next;
                pend_reg      <= pend_next;
            end
            out_v_reg   <= out_v_next;
            spare_v_reg <= spare_v_next;
        end
    end

    // Result payload registers carry no reset.
    always_ff @(posedge aclk) begin
        out_reg   <= out_next;
        spare_reg <= spare_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'b000000, out_reg.ovf, out_reg.length, out_reg.start};

    // A second result is only ever held behind a first one.
    `SCL_ASSERT_ALWAYS(a_spare_behind_out, !spare_v_reg || out_v_reg,
        "spare result without a first result")
    // A held operator always follows a cleared scan.
    `SCL_ASSERT_ALWAYS(a_pend_clear_scan, (pend_reg == scl_pkg::OP_NONE) ||
        (!in_word_reg && !in_quotes_reg && count_reg == '0), "operator held during a word")
    // Counting characters always leaves the word open.
    `SCL_ASSERT_NEXT(a_count_opens_word, pop && cnt_en,
        in_word_reg && open_reg && count_reg != '0, "counted character did not open a word")

endmodule

FILE: rtl/shell_command_lexer.sv
// Shell command lexer: one command-line byte per transfer on the s_ channel,
// shell tokens out on the m_ channel.
// s_tdata carries the byte; s_tlast marks end of line, which flushes any
// pending token and starts a fresh line (its byte is ignored).
// m_tuser carries the token kind; m_tdata carries token start, token length
// and the overflow flag; m_tlast is set on the last token caused by one input
// transfer. An input gives zero, one or two tokens.
// Path: the front end classifies a byte as it is accepted and writes it to the queue;
// the back end then pops it and registers its first token into the output stage.
// Throughput: one byte per cycle while m_tready is high; a byte that yields two tokens
// holds the back end until its second token leaves the spare slot for the output stage.
// The front end classifies and numbers bytes; a queue of QUEUE_DEPTH entries
// lets it keep accepting while the back end waits on the receiver.
// When m_tready is low, the output stage holds its token, then the queue
// fills and s_tready falls.
// Reset (aresetn low, synchronous) empties the queue and output stage and
// returns the line position, scan state and overflow flag to zero.
// Depends on scl_pkg, scl_front, scl_queue and scl_back.
module shell_command_lexer #(
    parameter int MAX_LINE    = scl_pkg::MAX_LINE_DEFAULT,
    parameter int QUEUE_DEPTH = scl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] token start, [24:12] token length,
                                   // [25] line_overflow
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast    // last_of_run
);

    localparam int AW    = $clog2(MAX_LINE);
    localparam int CTL_W = $bits(scl_pkg::scl_ctl_t);
    localparam int ITEM_W = CTL_W + AW;

    logic              f_valid, f_ready;
    scl_pkg::scl_ctl_t f_ctl;
    logic [AW-1:0]     f_at;
    logic              b_valid, b_ready;
    logic [ITEM_W-1:0] b_item;
    scl_pkg::scl_ctl_t b_ctl;
    logic [AW-1:0]     b_at;

    // Byte classification and position tracking.
    scl_front #(
        .MAX_LINE (MAX_LINE),
        .AW       (AW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_ctl    (f_ctl),
        .q_at     (f_at)
    );

    // Decoupling queue of classified items.
    scl_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_at, f_ctl}),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_item)
    );

    assign b_ctl = b_item[CTL_W-1:0];
    assign b_at  = b_item[ITEM_W-1:CTL_W];

    // Token state machine and result channel.
    scl_back #(
        .MAX_LINE (MAX_LINE),
        .AW       (AW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (b_valid),
        .q_ready  (b_ready),
        .q_ctl    (b_ctl),
        .q_at     (b_at),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
